// ----- rtl/core/tdvt_pkg.sv -----
`default_nettype none

package tdvt_pkg;

  typedef enum logic [1:0] {
    KIND_MOUSE    = 2'd0,
    KIND_TOUCH    = 2'd1,
    KIND_KEYBOARD = 2'd2,
    KIND_OTHER    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ACT_DOWN   = 3'd0,
    ACT_MOVE   = 3'd1,
    ACT_UP     = 3'd2,
    ACT_CANCEL = 3'd3,
    ACT_OTHER  = 3'd4
  } action_e;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned VEL_W    = 32;
  localparam int unsigned SLOP_W   = 16;

  localparam logic [SLOP_W-1:0] SLOP_RESET = 16'd8;
  localparam logic [VEL_W-1:0]  VEL_MAX    = 32'h7fff_ffff;
  localparam logic [VEL_W-1:0]  VEL_MIN    = 32'h8000_0000;

  // Blend (4*vel + inst) / 5, rounded: floor((sum + 2 + 5*2^34) / 5) keeps the
  // dividend positive; the bias adds 2^34 to the quotient, above the kept bits.
  localparam int unsigned        FIFTH_W     = 40;
  localparam int unsigned        FIFTH_DIG   = 8;
  localparam int unsigned        FIFTH_STEPS = FIFTH_W / FIFTH_DIG;
  localparam logic [FIFTH_W-1:0] FIFTH_BIAS  = 40'h14_0000_0002;
  localparam logic [3:0]         BLEND_DIV   = 4'd5;

  // Output beat: ring, drag, speed_x, speed_y, slop, zero fill
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned OUT_USED_W = 2 + 2 * VEL_W + 1;

  typedef struct packed {
    logic clear;
    logic start;
    logic div_step;
    logic sat_load;
    logic sum_load;
    logic fifth_step;
    logic vel_load;
  } lane_cmd_t;

  typedef struct packed {
    logic load;
    logic upd;
    logic div_step;
    logic sat_load;
    logic sum_load;
    logic fifth_step;
    logic vel_load;
    logic sqr_load;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic run_div;
  } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/tdvt_lane.sv -----
`default_nettype none

module tdvt_lane #(
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned VEL_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tdvt_pkg::lane_cmd_t             cmd_i,
  input  logic signed [COORD_BITS:0]      delta_i,
  input  logic [tdvt_pkg::TIME_W-1:0]     dt_i,
  output logic [tdvt_pkg::VEL_W-1:0]      vel_o
);

  localparam int unsigned NB = COORD_BITS + VEL_FRAC_BITS + 1;
  localparam int unsigned QW = (NB > 33) ? NB : 33;
  localparam int unsigned FW = tdvt_pkg::FIFTH_W;
  localparam int unsigned FD = tdvt_pkg::FIFTH_DIG;

  logic [NB-1:0]                   mag_q, mag_d;
  logic [tdvt_pkg::TIME_W-1:0]     rem_q, rem_d;
  logic                            neg_q;
  logic [tdvt_pkg::VEL_W-1:0]      inst_q, inst_w;
  logic [FW-1:0]                   acc_q, acc_d, acc_sum;
  logic [2:0]                      frem_q, frem_d;
  logic [tdvt_pkg::VEL_W-1:0]      vel_q;

  logic [COORD_BITS:0]             abs_w;
  logic [tdvt_pkg::TIME_W:0]       trial_w, diff_w;
  logic                            ge_w;
  logic [QW-1:0]                   quo_w;
  logic                            pos_ovf_w, neg_ovf_w;
  logic [3:0]                      fx_t;
  logic [2:0]                      fx_r;
  logic [FD-1:0]                   fx_q;

  assign abs_w = delta_i[COORD_BITS] ? (COORD_BITS + 1)'(-delta_i) : delta_i;

  // One restoring step: remainder stays below dt, quotient bits shift into mag
  assign trial_w = {rem_q, mag_q[NB-1]};
  assign ge_w    = trial_w >= {1'b0, dt_i};
  assign diff_w  = trial_w - {1'b0, dt_i};
  assign rem_d   = ge_w ? diff_w[tdvt_pkg::TIME_W-1:0] : trial_w[tdvt_pkg::TIME_W-1:0];
  assign mag_d   = {mag_q[NB-2:0], ge_w};

  assign quo_w     = QW'(mag_q);
  assign pos_ovf_w = |quo_w[QW-1:31];
  assign neg_ovf_w = (|quo_w[QW-1:32]) || (quo_w[31] && (|quo_w[30:0]));

  always_comb begin
    if (neg_q) begin
      inst_w = neg_ovf_w ? tdvt_pkg::VEL_MIN : tdvt_pkg::VEL_W'(-quo_w[31:0]);
    end else begin
      inst_w = pos_ovf_w ? tdvt_pkg::VEL_MAX : quo_w[31:0];
    end
  end

  assign acc_sum = {{6{vel_q[31]}}, vel_q, 2'b00}
                 + {{8{inst_q[31]}}, inst_q}
                 + tdvt_pkg::FIFTH_BIAS;

  // Divide by five, one byte of dividend per step
  always_comb begin
    fx_r = frem_q;
    fx_q = '0;
    fx_t = '0;
    for (int i = 0; i < FD; i++) begin
      fx_t = {fx_r, acc_q[FW-1-i]};
      if (fx_t >= tdvt_pkg::BLEND_DIV) begin
        fx_r = 3'(fx_t - tdvt_pkg::BLEND_DIV);
        fx_q[FD-1-i] = 1'b1;
      end else begin
        fx_r = fx_t[2:0];
      end
    end
  end

  assign acc_d  = {acc_q[FW-FD-1:0], fx_q};
  assign frem_d = fx_r;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mag_q <= {abs_w, {VEL_FRAC_BITS{1'b0}}};
      rem_q <= '0;
      neg_q <= delta_i[COORD_BITS];
    end else if (cmd_i.div_step) begin
      mag_q <= mag_d;
      rem_q <= rem_d;
    end
    if (cmd_i.sat_load) begin
      inst_q <= inst_w;
    end
    if (cmd_i.sum_load) begin
      acc_q  <= acc_sum;
      frem_q <= '0;
    end else if (cmd_i.fifth_step) begin
      acc_q  <= acc_d;
      frem_q <= frem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q <= '0;
    end else if (cmd_i.clear) begin
      vel_q <= '0;
    end else if (cmd_i.vel_load) begin
      vel_q <= acc_q[tdvt_pkg::VEL_W-1:0];
    end
  end

  assign vel_o = vel_q;

endmodule

`default_nettype wire

// ----- rtl/core/tdvt_datapath.sv -----
`default_nettype none

module tdvt_datapath #(
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned VEL_FRAC_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  tdvt_pkg::ctl_cmd_t                cmd_i,
  output tdvt_pkg::dp_sts_t                 sts_o,
  input  logic [tdvt_pkg::KIND_W-1:0]       kind_i,
  input  logic [tdvt_pkg::ACTION_W-1:0]     action_i,
  input  logic [COORD_BITS-1:0]             pos_x_i,
  input  logic [COORD_BITS-1:0]             pos_y_i,
  input  logic [tdvt_pkg::TIME_W-1:0]       time_i,
  input  logic                              cfg_we_i,
  input  logic [tdvt_pkg::SLOP_W-1:0]       cfg_data_i,
  output logic [tdvt_pkg::KIND_W-1:0]       modality_o,
  output logic                              ring_o,
  output logic                              drag_o,
  output logic [tdvt_pkg::VEL_W-1:0]        speed_x_o,
  output logic [tdvt_pkg::VEL_W-1:0]        speed_y_o,
  output logic                              slop_o
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned SQ_W  = 2 * C + 2;
  localparam int unsigned CMP_W = (SQ_W > 32) ? SQ_W : 32;

  logic [tdvt_pkg::KIND_W-1:0]    in_kind_q;
  logic [tdvt_pkg::ACTION_W-1:0]  in_act_q;
  logic [C-1:0]                   in_x_q, in_y_q;
  logic [tdvt_pkg::TIME_W-1:0]    in_time_q;

  logic [tdvt_pkg::SLOP_W-1:0]    slop_q;
  logic [tdvt_pkg::KIND_W-1:0]    modality_q;
  logic                           ring_q, drag_q;
  logic [C-1:0]                   org_x_q, org_y_q, last_x_q, last_y_q;
  logic [tdvt_pkg::TIME_W-1:0]    ltime_q, dt_q, dt_w;

  logic [SQ_W-1:0]                sqx_q, sqy_q;
  logic [31:0]                    s2_q;
  logic signed [C:0]              dx_w, dy_w, dlx_w, dly_w;
  logic signed [SQ_W-1:0]         sqx_w, sqy_w;
  logic [CMP_W-1:0]               d2_w;

  logic                           pointer_w, keyboard_w, down_w, move_w, end_w, run_w;
  tdvt_pkg::lane_cmd_t            lane_cmd;
  logic [tdvt_pkg::VEL_W-1:0]     vel_x_w, vel_y_w;

  logic [tdvt_pkg::KIND_W-1:0]    out_mod_q;
  logic                           out_ring_q, out_drag_q, out_slop_q;
  logic [tdvt_pkg::VEL_W-1:0]     out_vx_q, out_vy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_kind_q <= kind_i;
      in_act_q  <= action_i;
      in_x_q    <= pos_x_i;
      in_y_q    <= pos_y_i;
      in_time_q <= time_i;
    end
  end

  assign pointer_w  = (in_kind_q == tdvt_pkg::KIND_MOUSE) || (in_kind_q == tdvt_pkg::KIND_TOUCH);
  assign keyboard_w = in_kind_q == tdvt_pkg::KIND_KEYBOARD;
  assign down_w     = pointer_w && (in_act_q == tdvt_pkg::ACT_DOWN);
  assign move_w     = pointer_w && (in_act_q == tdvt_pkg::ACT_MOVE) && drag_q;
  assign end_w      = pointer_w && ((in_act_q == tdvt_pkg::ACT_UP) ||
                                    (in_act_q == tdvt_pkg::ACT_CANCEL));
  assign dt_w       = in_time_q - ltime_q;
  assign run_w      = move_w && (dt_w != '0);

  assign sts_o.run_div = run_w;

  assign dlx_w = $signed({in_x_q[C-1], in_x_q}) - $signed({last_x_q[C-1], last_x_q});
  assign dly_w = $signed({in_y_q[C-1], in_y_q}) - $signed({last_y_q[C-1], last_y_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slop_q     <= tdvt_pkg::SLOP_RESET;
      modality_q <= tdvt_pkg::KIND_MOUSE;
      ring_q     <= 1'b0;
      drag_q     <= 1'b0;
      org_x_q    <= '0;
      org_y_q    <= '0;
      last_x_q   <= '0;
      last_y_q   <= '0;
      ltime_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        slop_q <= cfg_data_i;
      end
      if (cmd_i.upd) begin
        modality_q <= in_kind_q;
        if (keyboard_w) begin
          ring_q <= 1'b1;
        end else if (down_w) begin
          ring_q <= 1'b0;
        end
        if (down_w) begin
          drag_q   <= 1'b1;
          org_x_q  <= in_x_q;
          org_y_q  <= in_y_q;
          last_x_q <= in_x_q;
          last_y_q <= in_y_q;
          ltime_q  <= in_time_q;
        end else if (move_w) begin
          last_x_q <= in_x_q;
          last_y_q <= in_y_q;
          ltime_q  <= in_time_q;
        end else if (end_w) begin
          drag_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      dt_q <= dt_w;
    end
  end

  assign lane_cmd.clear      = cmd_i.upd && down_w;
  assign lane_cmd.start      = cmd_i.upd && run_w;
  assign lane_cmd.div_step   = cmd_i.div_step;
  assign lane_cmd.sat_load   = cmd_i.sat_load;
  assign lane_cmd.sum_load   = cmd_i.sum_load;
  assign lane_cmd.fifth_step = cmd_i.fifth_step;
  assign lane_cmd.vel_load   = cmd_i.vel_load;

  tdvt_lane #(
    .COORD_BITS    (COORD_BITS),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (lane_cmd),
    .delta_i (dlx_w),
    .dt_i    (dt_q),
    .vel_o   (vel_x_w)
  );

  tdvt_lane #(
    .COORD_BITS    (COORD_BITS),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (lane_cmd),
    .delta_i (dly_w),
    .dt_i    (dt_q),
    .vel_o   (vel_y_w)
  );

  // Drag distance squared against slop squared
  assign dx_w  = $signed({last_x_q[C-1], last_x_q}) - $signed({org_x_q[C-1], org_x_q});
  assign dy_w  = $signed({last_y_q[C-1], last_y_q}) - $signed({org_y_q[C-1], org_y_q});
  assign sqx_w = SQ_W'(dx_w) * SQ_W'(dx_w);
  assign sqy_w = SQ_W'(dy_w) * SQ_W'(dy_w);
  assign d2_w  = CMP_W'(sqx_q) + CMP_W'(sqy_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqr_load) begin
      sqx_q <= sqx_w;
      sqy_q <= sqy_w;
      s2_q  <= 32'(slop_q) * 32'(slop_q);
    end
    if (cmd_i.out_load) begin
      out_mod_q  <= modality_q;
      out_ring_q <= ring_q;
      out_drag_q <= drag_q;
      out_vx_q   <= vel_x_w;
      out_vy_q   <= vel_y_w;
      out_slop_q <= drag_q && (d2_w >= CMP_W'(s2_q));
    end
  end

  assign modality_o = out_mod_q;
  assign ring_o     = out_ring_q;
  assign drag_o     = out_drag_q;
  assign speed_x_o  = out_vx_q;
  assign speed_y_o  = out_vy_q;
  assign slop_o     = out_slop_q;

endmodule

`default_nettype wire

// ----- rtl/core/tdvt_ctrl.sv -----
`default_nettype none

module tdvt_ctrl #(
  parameter int unsigned DIV_STEPS = 33
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  input  tdvt_pkg::dp_sts_t   sts_i,
  output tdvt_pkg::ctl_cmd_t  cmd_o
);

  localparam int unsigned CW = $clog2(DIV_STEPS);
  localparam logic [CW-1:0] DIV_LAST   = CW'(DIV_STEPS - 1);
  localparam logic [CW-1:0] FIFTH_LAST = CW'(tdvt_pkg::FIFTH_STEPS - 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_UPD   = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_SAT   = 9'b000001000,
    S_SUM   = 9'b000010000,
    S_FIFTH = 9'b000100000,
    S_VEL   = 9'b001000000,
    S_SQR   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            out_vld_q, out_vld_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        cnt_d     = '0;
        state_d   = sts_i.run_div ? S_DIV : S_SQR;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = S_SAT;
        end
      end
      S_SAT: begin
        cmd_o.sat_load = 1'b1;
        state_d        = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_FIFTH;
      end
      S_FIFTH: begin
        cmd_o.fifth_step = 1'b1;
        cnt_d            = cnt_q + CW'(1);
        if (cnt_q == FIFTH_LAST) begin
          state_d = S_VEL;
        end
      end
      S_VEL: begin
        cmd_o.vel_load = 1'b1;
        state_d        = S_SQR;
      end
      S_SQR: begin
        cmd_o.sqr_load = 1'b1;
        state_d        = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_vld_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_vld_d = cmd_o.out_load ? 1'b1 : (m_ready_i ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign s_ready_o = state_q == S_IDLE;
  assign m_valid_o = out_vld_q;

  ap_accept_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_UPD))
    else $error("accepted beat did not start an update");

  ap_skip_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !sts_i.run_div) |=> (state_q == S_SQR))
    else $error("divider entered without a velocity update");

  ap_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SAT) |-> ($past(state_q) == S_DIV && $past(cnt_q) == DIV_LAST))
    else $error("division left before all quotient bits");

  ap_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_vld_q && state_q == S_IDLE))
    else $error("result load did not present a beat");

endmodule

`default_nettype wire

// ----- rtl/core/touch_drag_velocity_tracker.sv -----
`default_nettype none

// Tracks pointer and keyboard events and returns one result beat per event:
// modality, focus-ring and drag flags, smoothed X/Y velocity (signed Q15.16
// px/ms at the default VEL_FRAC_BITS) and the touch-slop check. One event is
// processed at a time. An event with no velocity update passes through the
// update, slop square and result load steps from acceptance to a valid result,
// then returns to idle to accept the next event. A move during a drag with a
// nonzero interval also runs the bit-serial divider that forms one quotient bit
// per cycle (COORD_BITS + VEL_FRAC_BITS + 1 steps), with both axes divided side
// by side, then saturate, sum, the divide-by-five blend and velocity load, before
// slop square, result load and idle.
// A new event is accepted while the previous result still waits on m_axis.

module touch_drag_velocity_tracker #(
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned VEL_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // pos_x, pos_y, time_ms, zero fill
  input  logic [((2*COORD_BITS+32+7)/8)*8-1:0]  s_axis_tdata,
  // event_kind, event_action
  input  logic [4:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // ring_visible, drag_active, speed_x, speed_y, slop_exceeded, zero fill
  output logic [tdvt_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // modality
  output logic [1:0]                            m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [tdvt_pkg::SLOP_W-1:0]           cfg_data_i
);

  localparam int unsigned C = COORD_BITS;

  tdvt_pkg::ctl_cmd_t          cmd;
  tdvt_pkg::dp_sts_t           sts;
  logic                        ring, drag, slop;
  logic [tdvt_pkg::VEL_W-1:0]  speed_x, speed_y;

  assign cfg_ready_o = 1'b1;

  tdvt_ctrl #(
    .DIV_STEPS (COORD_BITS + VEL_FRAC_BITS + 1)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tdvt_datapath #(
    .COORD_BITS    (COORD_BITS),
    .VEL_FRAC_BITS (VEL_FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .kind_i     (s_axis_tuser[1:0]),
    .action_i   (s_axis_tuser[4:2]),
    .pos_x_i    (s_axis_tdata[C-1:0]),
    .pos_y_i    (s_axis_tdata[2*C-1:C]),
    .time_i     (s_axis_tdata[2*C+31:2*C]),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .modality_o (m_axis_tuser),
    .ring_o     (ring),
    .drag_o     (drag),
    .speed_x_o  (speed_x),
    .speed_y_o  (speed_y),
    .slop_o     (slop)
  );

  assign m_axis_tdata = {{(tdvt_pkg::OUT_DATA_W - tdvt_pkg::OUT_USED_W){1'b0}},
                         slop, speed_y, speed_x, drag, ring};

endmodule

`default_nettype wire
